/* src/gcpm_pkg.sv */
// shared types and constants of the closest pair matcher
package gcpm_pkg;

  localparam int RESULT_CAP = 64;
  localparam int KW = $clog2(RESULT_CAP + 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROWA,
    ST_ROWB,
    ST_PAIR,
    ST_DRAIN,
    ST_DECIDE,
    ST_REM,
    ST_REMW,
    ST_LSCAN,
    ST_LGET,
    ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    RD_ROW,
    RD_COL,
    RD_SCAN
  } rsel_t;

  typedef struct packed {
    rsel_t rsel;
    logic  load;
    logic  scan_init;
    logic  row_next;
    logic  row_latch;
    logic  pair_issue;
    logic  scan_reset;
    logic  scan_inc;
    logic  rem_issue;
    logic  push;
    logic  push_last;
    logic  set_pair;
    logic  set_single;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic row_last;
    logic a_alive;
    logic col_last;
    logic pipe_busy;
    logic found;
    logic pend_valid;
    logic out_free;
    logic cap_next;
    logic m_last;
    logic m_alive;
  } sts_t;

endpackage

/* src/gcpm_ctrl.sv */
// controller state machine of the closest pair matcher
module gcpm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tlast,
  output logic          s_tready,
  input  gcpm_pkg::sts_t sts,
  output gcpm_pkg::cmd_t cmd
);

  gcpm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcpm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rsel = gcpm_pkg::RD_ROW;
    s_tready = 1'b0;
    case (state)
      gcpm_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            cmd.scan_init = 1'b1;
            state_next = gcpm_pkg::ST_ROWA;
          end
        end
      end
      gcpm_pkg::ST_ROWA: begin
        if (sts.row_last) begin
          state_next = gcpm_pkg::ST_DRAIN;
        end else if (!sts.a_alive) begin
          cmd.row_next = 1'b1;
        end else begin
          state_next = gcpm_pkg::ST_ROWB;
        end
      end
      gcpm_pkg::ST_ROWB: begin
        cmd.row_latch = 1'b1;
        state_next = gcpm_pkg::ST_PAIR;
      end
      gcpm_pkg::ST_PAIR: begin
        cmd.rsel = gcpm_pkg::RD_COL;
        cmd.pair_issue = 1'b1;
        if (sts.col_last) begin
          cmd.row_next = 1'b1;
          state_next = gcpm_pkg::ST_ROWA;
        end
      end
      gcpm_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = gcpm_pkg::ST_DECIDE;
        end
      end
      gcpm_pkg::ST_DECIDE: begin
        if (!sts.found) begin
          cmd.scan_reset = 1'b1;
          state_next = gcpm_pkg::ST_LSCAN;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.push = sts.pend_valid;
          cmd.set_pair = 1'b1;
          if (sts.cap_next) begin
            state_next = gcpm_pkg::ST_FINAL;
          end else begin
            cmd.scan_reset = 1'b1;
            state_next = gcpm_pkg::ST_REM;
          end
        end
      end
      gcpm_pkg::ST_REM: begin
        cmd.rsel = gcpm_pkg::RD_SCAN;
        cmd.rem_issue = 1'b1;
        cmd.scan_inc = 1'b1;
        if (sts.m_last) begin
          state_next = gcpm_pkg::ST_REMW;
        end
      end
      gcpm_pkg::ST_REMW: begin
        cmd.scan_init = 1'b1;
        state_next = gcpm_pkg::ST_ROWA;
      end
      gcpm_pkg::ST_LSCAN: begin
        cmd.rsel = gcpm_pkg::RD_SCAN;
        if (sts.m_alive) begin
          state_next = gcpm_pkg::ST_LGET;
        end else if (sts.m_last) begin
          state_next = gcpm_pkg::ST_FINAL;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      gcpm_pkg::ST_LGET: begin
        cmd.rsel = gcpm_pkg::RD_SCAN;
        if (!sts.pend_valid || sts.out_free) begin
          cmd.push = sts.pend_valid;
          cmd.set_single = 1'b1;
          state_next = gcpm_pkg::ST_FINAL;
        end
      end
      gcpm_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          cmd.push_last = 1'b1;
          cmd.clear = 1'b1;
          state_next = gcpm_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = gcpm_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

/* src/gcpm_datapath.sv */
// point store, pair distance pipeline, removal and result registers
module gcpm_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  gcpm_pkg::cmd_t cmd,
  output gcpm_pkg::sts_t sts,
  input  logic [31:0]    s_tdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [63:0]    m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CB = COORD_BITS;
  localparam int DW = 2 * CB + 1;

  logic [2*CB-1:0] mem [MAX_POINTS];
  logic [2*CB-1:0] rdata;
  logic [IW-1:0]   raddr;

  logic [CW-1:0]         count;
  logic [MAX_POINTS-1:0] alive;
  logic [IW-1:0]         ci, cj, cm, ia, rm;
  logic [CB-1:0]         ax, ay, rx, ry;
  logic                  rv;

  logic          v1, v2, v3;
  logic [IW-1:0] ib1, ia2, ib2, ia3, ib3;
  logic [CB-1:0] dx, dy, ax2, ay2, bx2, by2, ax3, ay3, bx3, by3;
  logic [2*CB-1:0] sqx, sqy;

  logic          found;
  logic [DW-1:0] best;
  logic [CB-1:0] lx, ly, hx, hy;
  logic [IW-1:0] li, hi;

  logic          pend_valid;
  logic [CB-1:0] pfx, pfy, psx, psy;
  logic          pu;
  logic [gcpm_pkg::KW-1:0] k;

  logic [DW-1:0] d;
  logic          b_first, better, swap;
  logic [CB-1:0] cx_lo, cy_lo, cx_hi, cy_hi;
  logic [IW-1:0] ci_lo, ci_hi;

  function automatic logic sorts_ahead(input logic [CB-1:0] x0, input logic [CB-1:0] y0,
                                       input logic [IW-1:0] i0, input logic [CB-1:0] x1,
                                       input logic [CB-1:0] y1, input logic [IW-1:0] i1);
    sorts_ahead = (x0 < x1) || ((x0 == x1) && (y0 < y1)) ||
                  ((x0 == x1) && (y0 == y1) && (i0 < i1));
  endfunction

  assign rx = rdata[CB-1:0];
  assign ry = rdata[2*CB-1:CB];

  always_comb begin
    case (cmd.rsel)
      gcpm_pkg::RD_COL:  raddr = cj;
      gcpm_pkg::RD_SCAN: raddr = cm;
      default:           raddr = ci;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (count < CW'(MAX_POINTS))) begin
      mem[count[IW-1:0]] <= {CB'(s_tdata[31:16]), CB'(s_tdata[15:0])};
    end
    rdata <= mem[raddr];
  end

  // distance and tie order of the pair at the end of the pipeline
  always_comb begin
    d = DW'(sqx) + DW'(sqy);
    b_first = (bx3 < ax3) || ((bx3 == ax3) && (by3 < ay3));
    cx_lo = b_first ? bx3 : ax3;
    cy_lo = b_first ? by3 : ay3;
    ci_lo = b_first ? ib3 : ia3;
    cx_hi = b_first ? ax3 : bx3;
    cy_hi = b_first ? ay3 : by3;
    ci_hi = b_first ? ia3 : ib3;
    better = !found || (d < best) ||
             ((d == best) && (sorts_ahead(cx_lo, cy_lo, ci_lo, lx, ly, li) ||
              ((ci_lo == li) && sorts_ahead(cx_hi, cy_hi, ci_hi, hx, hy, hi))));
    swap = (hy < ly) || ((hy == ly) && (hx < lx));
  end

  always_ff @(posedge clk) begin
    ib1 <= cj;
    dx  <= (ax > rx) ? ax - rx : rx - ax;
    dy  <= (ay > ry) ? ay - ry : ry - ay;
    ax2 <= ax;
    ay2 <= ay;
    ia2 <= ia;
    bx2 <= rx;
    by2 <= ry;
    ib2 <= ib1;
    sqx <= dx * dx;
    sqy <= dy * dy;
    ax3 <= ax2;
    ay3 <= ay2;
    ia3 <= ia2;
    bx3 <= bx2;
    by3 <= by2;
    ib3 <= ib2;
    rm  <= cm;
    if (cmd.row_latch) begin
      ax <= rx;
      ay <= ry;
      ia <= ci;
    end
    if (v3 && better) begin
      best <= d;
      lx <= cx_lo;
      ly <= cy_lo;
      li <= ci_lo;
      hx <= cx_hi;
      hy <= cy_hi;
      hi <= ci_hi;
    end
    if (cmd.set_pair) begin
      pfx <= swap ? hx : lx;
      pfy <= swap ? hy : ly;
      psx <= swap ? lx : hx;
      psy <= swap ? ly : hy;
      pu  <= 1'b0;
    end else if (cmd.set_single) begin
      pfx <= rx;
      pfy <= ry;
      psx <= '0;
      psy <= '0;
      pu  <= 1'b1;
    end
    if (cmd.push) begin
      m_tdata <= {16'(psy), 16'(psx), 16'(pfy), 16'(pfx)};
      m_tuser <= pu;
      m_tlast <= cmd.push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      alive      <= '0;
      ci         <= '0;
      cj         <= '0;
      cm         <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      rv         <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      k          <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      v1 <= cmd.pair_issue && alive[cj];
      v2 <= v1;
      v3 <= v2;
      rv <= cmd.rem_issue;
      if (cmd.load && (count < CW'(MAX_POINTS))) begin
        alive[count[IW-1:0]] <= 1'b1;
        count <= count + 1'b1;
      end
      if (rv && ((rdata == {ly, lx}) || (rdata == {hy, hx}))) begin
        alive[rm] <= 1'b0;
      end
      if (cmd.scan_init) begin
        ci <= '0;
        found <= 1'b0;
      end else if (cmd.row_next) begin
        ci <= ci + 1'b1;
      end
      if (cmd.row_latch) begin
        cj <= ci + 1'b1;
      end else if (cmd.pair_issue) begin
        cj <= cj + 1'b1;
      end
      if (v3) begin
        found <= 1'b1;
      end
      if (cmd.scan_reset) begin
        cm <= '0;
      end else if (cmd.scan_inc) begin
        cm <= cm + 1'b1;
      end
      if (cmd.set_pair || cmd.set_single) begin
        pend_valid <= 1'b1;
        k <= k + 1'b1;
      end else if (cmd.push) begin
        pend_valid <= 1'b0;
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.clear) begin
        count <= '0;
        alive <= '0;
        k     <= '0;
      end
    end
  end

  always_comb begin
    sts.row_last   = (CW'(ci) + 1'b1) >= count;
    sts.a_alive    = alive[ci];
    sts.col_last   = (CW'(cj) + 1'b1) >= count;
    sts.pipe_busy  = v1 || v2 || v3;
    sts.found      = found;
    sts.pend_valid = pend_valid;
    sts.out_free   = !m_tvalid || m_tready;
    sts.cap_next   = k == gcpm_pkg::KW'(gcpm_pkg::RESULT_CAP - 1);
    sts.m_last     = (CW'(cm) + 1'b1) >= count;
    sts.m_alive    = alive[cm];
  end

endmodule

/* src/greedy_closest_pair_matcher_top.sv */
// top level of the greedy closest pair matcher
//
// points enter on the s_ side, one per item, x in s_tdata[15:0] and y in
// s_tdata[31:16]; s_tlast marks the last point of a set and starts matching.
// up to MAX_POINTS points are kept, later ones of the same set are dropped.
// results leave on the m_ side, one pair per item with the lower-y point
// first; a lone leftover point comes with m_tuser set and zero second point.
// m_tlast marks the final result of the set.
// during loading every valid point is taken. each matching pass walks the
// rows of the held points, skipping removed rows, and feeds each live row
// point against every later index, one pair per cycle, through a distance
// pipeline; a drain of that pipeline, a decision and a removal pass over
// all held points follow each result. s_tready stays low from the last point
// until the final result has been handed to the output register.
// a stall on m_tready holds the output register and the matcher waits
// before it overwrites it. reset empties the set and drops any result.
module greedy_closest_pair_matcher_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // x_coord, y_coord
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // first_x, first_y, second_x, second_y
  output logic        m_tuser,   // is_unconnected
  output logic        m_tlast    // last_result
);

  gcpm_pkg::cmd_t cmd;
  gcpm_pkg::sts_t sts;

  gcpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcpm_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/gcpm_checker.sv */
// port checks of the closest pair matcher and their binding
module gcpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  a_load_stop: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken after last point");

  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[63:32] == 32'd0 && m_tlast)
    else $error("leftover item malformed");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:16] <= m_tdata[63:48])
    else $error("pair not ordered by y");

endmodule

bind greedy_closest_pair_matcher_top gcpm_checker u_gcpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
